@@ hdl/sebp_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// sebp_pkg
// Constants shared by the serial EEPROM bit protocol block: DMA lengths that
// select the wide address, bit counts that end each phase of a transfer.
// -----------------------------------------------------------------------------
package sebp_pkg;

   // DMA lengths that select the 14-bit address form
   localparam logic [15:0] WIDE_LEN_A = 16'h0011;
   localparam logic [15:0] WIDE_LEN_B = 16'h0051;

   // bit counts, counted from the start bit, that close the address phase
   localparam logic [6:0] NARROW_ADDR_END = 7'd9;
   localparam logic [6:0] WIDE_ADDR_END   = 7'd17;

   // write phase: commit after the 64th data bit, stop bit after that
   localparam logic [6:0] WRITE_COMMIT = 7'h40;
   localparam logic [6:0] WRITE_STOP   = 7'h41;

   // read phase: zero bits ahead of the data, then 64 data bits
   localparam logic [6:0] LEAD_BITS = 7'd4;
   localparam logic [6:0] DATA_END  = 7'h40;

   // shift buffer depth in bytes
   localparam int BUF_BYTES = 9;

   // bit of the first address byte that marks a read request
   localparam int READ_FLAG_BIT = 6;

endpackage

`default_nettype wire

@@ hdl/serial_eeprom_bit_protocol.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// serial_eeprom_bit_protocol
// Bit-serial cartridge EEPROM: request and address bits, 64-bit word writes
// and reads over a one-bit-per-beat stream, backed by a WORDS x 64 store.
// -----------------------------------------------------------------------------
// Usage: every request beat is one serial access. req_tuser = 0 is a bit
// write (req_tdata carries the bit and the current DMA length), req_tuser = 1
// is a bit read that returns one response beat. The block takes one beat per
// clock cycle for as long as the response register is free or drained in the
// same cycle; a read answer is registered and appears in the cycle after its
// request beat. After reset a clearing pass sets every word of the store to
// all ones, one word a cycle, so req_tready stays low until the pass is done.
// The word addressed by a read is fetched from the store during the four
// lead-in bits, so data bits stream out at full rate. Addresses wrap modulo
// WORDS.
// -----------------------------------------------------------------------------
module serial_eeprom_bit_protocol #(
   parameter int WORDS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [0] write_bit, [16:1] dma_count, rest zero
   input  wire logic        req_tuser,   // [0] command: 0 bit write, 1 bit read
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // [0] read_bit, rest zero
);

   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int NB = sebp_pkg::BUF_BYTES;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_ADDR  = 3'd1,
      MODE_WRITE = 3'd2,
      MODE_LEAD  = 3'd3,
      MODE_DATA  = 3'd4
   } mode_type;

   // reduce a 10-bit word address modulo WORDS (quotient fits in 4 bits)
   function automatic logic [AW-1:0] wrap_address(input logic [9:0] a);
      logic [13:0] r;
      r = {4'd0, a};
      for (int k = 3; k >= 0; k--) begin
         if (r >= (14'(WORDS) << k)) begin
            r = r - (14'(WORDS) << k);
         end
      end
      return r[AW-1:0];
   endfunction

   // protocol state
   mode_type      mode_ff,         mode_in;
   logic [6:0]    bit_count_ff,    bit_count_in;
   logic [3:0]    byte_index_ff,   byte_index_in;
   logic [AW-1:0] word_address_ff, word_address_in;
   logic [7:0]    bytes_ff [NB];
   logic [7:0]    bytes_in [NB];

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_bit_ff,   rsp_bit_in;

   // clearing pass after reset
   logic          clear_busy_ff;
   logic [AW-1:0] clear_addr_ff;

   // store
   logic [63:0]   mem [WORDS];
   logic [63:0]   rd_word_ff;
   logic          commit;
   logic [63:0]   commit_word;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [63:0]   mem_wdata;

   // request fields
   logic          accept;
   logic          cmd_read;
   logic          wbit;
   logic [15:0]   dma_count;
   logic          wide;

   // one shifted-in bit, shared by the address and write phases
   logic [7:0]    sh_bytes [NB];
   logic [6:0]    sh_count;
   logic [3:0]    sh_index;
   logic [5:0]    data_pos;

   assign cmd_read  = req_tuser;
   assign wbit      = req_tdata[0];
   assign dma_count = req_tdata[16:1];
   assign wide      = (dma_count == sebp_pkg::WIDE_LEN_A) ||
                      (dma_count == sebp_pkg::WIDE_LEN_B);

   assign req_tready = !clear_busy_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_bit_ff};

   // shift the write bit into the current buffer byte; bytes past the end drop it
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         if (byte_index_ff == 4'(i)) begin
            sh_bytes[i] = {bytes_ff[i][6:0], wbit};
         end else begin
            sh_bytes[i] = bytes_ff[i];
         end
      end
      sh_count = bit_count_ff + 7'd1;
      sh_index = (sh_count[2:0] == 3'd0) ? byte_index_ff + 4'd1 : byte_index_ff;
   end

   // first byte of the buffer is the most significant byte of the word
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         commit_word[63 - 8*i -: 8] = sh_bytes[i];
      end
   end

   assign data_pos = {byte_index_ff[2:0], bit_count_ff[2:0]};

   // next-state logic
   always_comb begin
      mode_in         = mode_ff;
      bit_count_in    = bit_count_ff;
      byte_index_in   = byte_index_ff;
      word_address_in = word_address_ff;
      for (int i = 0; i < NB; i++) begin
         bytes_in[i] = bytes_ff[i];
      end
      commit       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bit_in   = rsp_bit_ff;

      if (accept && cmd_read) begin
         rsp_valid_in = 1'b1;
         case (mode_ff)
            MODE_IDLE, MODE_ADDR, MODE_WRITE: begin
               rsp_bit_in = 1'b1;
            end
            MODE_LEAD: begin
               // answer zeros until the lead-in is done
               rsp_bit_in   = 1'b0;
               bit_count_in = sh_count;
               if (sh_count == sebp_pkg::LEAD_BITS) begin
                  mode_in       = MODE_DATA;
                  bit_count_in  = 7'd0;
                  byte_index_in = 4'd0;
               end
            end
            MODE_DATA: begin
               // stream the prefetched word, most significant bit first
               rsp_bit_in    = rd_word_ff[6'd63 - data_pos];
               bit_count_in  = sh_count;
               byte_index_in = sh_index;
               if (sh_count == sebp_pkg::DATA_END) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               rsp_bit_in = 1'b0;
            end
         endcase
      end else if (accept && dma_count != 16'd0) begin
         case (mode_ff)
            MODE_IDLE: begin
               // start bit opens the address phase
               byte_index_in = 4'd0;
               bit_count_in  = 7'd1;
               bytes_in[0]   = {7'd0, wbit};
               mode_in       = MODE_ADDR;
            end
            MODE_ADDR: begin
               for (int i = 0; i < NB; i++) begin
                  bytes_in[i] = sh_bytes[i];
               end
               bit_count_in  = sh_count;
               byte_index_in = sh_index;
               if ((wide && sh_count == sebp_pkg::WIDE_ADDR_END) ||
                   (!wide && sh_count == sebp_pkg::NARROW_ADDR_END)) begin
                  if (wide) begin
                     word_address_in = wrap_address({sh_bytes[0][1:0], sh_bytes[1]});
                  end else begin
                     word_address_in = wrap_address({4'd0, sh_bytes[0][5:0]});
                  end
                  if (!sh_bytes[0][sebp_pkg::READ_FLAG_BIT]) begin
                     // deciding bit doubles as the first data bit
                     bytes_in[0]   = {7'd0, wbit};
                     bit_count_in  = 7'd1;
                     byte_index_in = 4'd0;
                     mode_in       = MODE_WRITE;
                  end else begin
                     mode_in       = MODE_LEAD;
                     bit_count_in  = 7'd0;
                     byte_index_in = 4'd0;
                  end
               end
            end
            MODE_LEAD, MODE_DATA: begin
               mode_in = MODE_IDLE;
            end
            MODE_WRITE: begin
               for (int i = 0; i < NB; i++) begin
                  bytes_in[i] = sh_bytes[i];
               end
               bit_count_in  = sh_count;
               byte_index_in = sh_index;
               if (sh_count == sebp_pkg::WRITE_COMMIT) begin
                  commit = 1'b1;
               end else if (sh_count == sebp_pkg::WRITE_STOP) begin
                  mode_in       = MODE_IDLE;
                  byte_index_in = 4'd0;
                  bit_count_in  = 7'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         bit_count_ff    <= 7'd0;
         byte_index_ff   <= 4'd0;
         word_address_ff <= '0;
         for (int i = 0; i < NB; i++) begin
            bytes_ff[i] <= 8'd0;
         end
         rsp_valid_ff    <= 1'b0;
         rsp_bit_ff      <= 1'b0;
         clear_busy_ff   <= 1'b1;
         clear_addr_ff   <= '0;
      end else begin
         mode_ff         <= mode_in;
         bit_count_ff    <= bit_count_in;
         byte_index_ff   <= byte_index_in;
         word_address_ff <= word_address_in;
         for (int i = 0; i < NB; i++) begin
            bytes_ff[i] <= bytes_in[i];
         end
         rsp_valid_ff    <= rsp_valid_in;
         rsp_bit_ff      <= rsp_bit_in;
         if (clear_busy_ff) begin
            clear_addr_ff <= clear_addr_ff + AW'(1);
            if (clear_addr_ff == AW'(WORDS - 1)) begin
               clear_busy_ff <= 1'b0;
            end
         end
      end
   end

   // one write port: clearing pass or word commit
   assign mem_we    = clear_busy_ff || commit;
   assign mem_waddr = clear_busy_ff ? clear_addr_ff : word_address_ff;
   assign mem_wdata = clear_busy_ff ? {64{1'b1}} : commit_word;

   // store; the read port follows the latched address, so the word is ready
   // well before the lead-in bits are through
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff <= mem[word_address_ff];
   end

endmodule

`default_nettype wire

@@ verif/serial_eeprom_bit_protocol_tb.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// serial_eeprom_bit_protocol_tb
// Self-checking bench for the serial EEPROM bit protocol. It streams serial
// bit writes and bit reads, tracks the EEPROM state and word store in a local
// model, and checks every returned read bit in order. It opens with a short
// directed pass, then runs random narrow and wide transfers, aborted reads,
// DMA-length changes during addressing, overrunning address phases and stray
// accesses. Both handshakes are throttled at random.
// -----------------------------------------------------------------------------
module serial_eeprom_bit_protocol_tb;

   localparam int WORDS       = 1024;
   localparam int BEAT_TARGET = 1050;     // stop adding random traffic past this
   localparam int CYCLE_LIMIT = 200000;   // timeout; covers the clearing pass
   localparam int DRAIN_TAIL  = 16;       // quiet cycles after the last read bit

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // protocol phases tracked by the local model
   typedef enum logic [2:0] {
      MODE_IDLE, MODE_ADDR, MODE_WRITE, MODE_LEAD, MODE_DATA
   } access_mode_type;

   // one serial access; hold makes the driver wait for all read bits first
   typedef struct packed {
      logic        hold;
      logic        cmd;
      logic [15:0] dma;
      logic        wbit;
   } serial_beat_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [0] write_bit, [16:1] dma_count, rest zero
   logic        req_tuser  = 1'b0; // [0] command: 0 bit write, 1 bit read
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] read_bit, rest zero

   serial_eeprom_bit_protocol #(.WORDS(WORDS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   serial_beat_type pending_beats[$];
   serial_beat_type on_bus;
   logic         expected_read_bits[$];
   logic         wanted_bit;
   logic [9:0]   written_words[$];
   int           counted_beats = 0;
   int           mismatches    = 0;
   int           cycle_count   = 0;
   int           gap_left, burst_left, ready_left, stall_left;

   // ---------------------------------------------------------------------------
   // Local EEPROM model: phase, counters, latched word, shift buffer and store
   // ---------------------------------------------------------------------------
   access_mode_type acc_mode;
   logic [6:0]   acc_bits;
   logic [3:0]   acc_byte;
   logic [9:0]   acc_word;
   logic [7:0]   acc_shift [sebp_pkg::BUF_BYTES];
   logic [63:0]  eeprom_words [WORDS];

   function void clear_eeprom_state();
      acc_mode = MODE_IDLE;
      acc_bits = '0;
      acc_byte = '0;
      acc_word = '0;
      for (int i = 0; i < sebp_pkg::BUF_BYTES; i++) acc_shift[i] = '0;
      for (int i = 0; i < WORDS; i++) eeprom_words[i] = '1;
   endfunction

   // count one serial bit; the byte index steps on each byte boundary
   function void bump_bit_count();
      acc_bits = acc_bits + 7'd1;
      if (acc_bits[2:0] == 3'd0) acc_byte = acc_byte + 4'd1;
   endfunction

   // bytes past the end of the buffer swallow their bits
   function void shift_serial_bit(logic b);
      if (acc_byte < sebp_pkg::BUF_BYTES)
         acc_shift[acc_byte] = {acc_shift[acc_byte][6:0], b};
      bump_bit_count();
   endfunction

   function void predict_serial_access(serial_beat_type beat);
      logic       wide;
      logic [5:0] pos;
      logic       bit_out;
      if (beat.cmd == CMD_READ) begin
         bit_out = 1'b0;
         case (acc_mode)
            MODE_IDLE, MODE_ADDR, MODE_WRITE: bit_out = 1'b1;
            MODE_LEAD: begin
               acc_bits = acc_bits + 7'd1;
               if (acc_bits == sebp_pkg::LEAD_BITS) begin
                  acc_mode = MODE_DATA;
                  acc_bits = '0;
                  acc_byte = '0;
               end
            end
            MODE_DATA: begin
               // most significant bit of the word goes out first
               pos     = {acc_byte[2:0], acc_bits[2:0]};
               bit_out = eeprom_words[acc_word % WORDS][63 - pos];
               bump_bit_count();
               if (acc_bits == sebp_pkg::DATA_END) acc_mode = MODE_IDLE;
            end
            default: bit_out = 1'b0;
         endcase
         expected_read_bits.push_back(bit_out);
      end else if (beat.dma != 16'h0000) begin
         case (acc_mode)
            MODE_IDLE: begin
               acc_byte     = '0;
               acc_bits     = 7'd1;
               acc_shift[0] = {7'b0, beat.wbit};
               acc_mode     = MODE_ADDR;
            end
            MODE_ADDR: begin
               // the end test follows the length of this very beat
               wide = (beat.dma == sebp_pkg::WIDE_LEN_A) ||
                      (beat.dma == sebp_pkg::WIDE_LEN_B);
               shift_serial_bit(beat.wbit);
               if ((wide && acc_bits == sebp_pkg::WIDE_ADDR_END) ||
                   (!wide && acc_bits == sebp_pkg::NARROW_ADDR_END)) begin
                  if (wide) acc_word = {acc_shift[0][1:0], acc_shift[1]};
                  else      acc_word = {4'b0, acc_shift[0][5:0]};
                  if (!acc_shift[0][sebp_pkg::READ_FLAG_BIT]) begin
                     // the closing bit doubles as the first data bit
                     acc_shift[0] = {7'b0, beat.wbit};
                     acc_bits     = 7'd1;
                     acc_byte     = '0;
                     acc_mode     = MODE_WRITE;
                  end else begin
                     acc_mode = MODE_LEAD;
                     acc_bits = '0;
                     acc_byte = '0;
                  end
               end
            end
            MODE_LEAD, MODE_DATA: acc_mode = MODE_IDLE;
            MODE_WRITE: begin
               shift_serial_bit(beat.wbit);
               if (acc_bits == sebp_pkg::WRITE_COMMIT) begin
                  eeprom_words[acc_word % WORDS] = {acc_shift[0], acc_shift[1],
                     acc_shift[2], acc_shift[3], acc_shift[4], acc_shift[5],
                     acc_shift[6], acc_shift[7]};
               end else if (acc_bits == sebp_pkg::WRITE_STOP) begin
                  acc_mode = MODE_IDLE;
                  acc_byte = '0;
                  acc_bits = '0;
               end
            end
            default: ;
         endcase
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus building blocks
   // ---------------------------------------------------------------------------
   function void push_beat(logic cmd, logic wbit, logic [15:0] dma, logic hold);
      serial_beat_type b;
      b.hold = hold;
      b.cmd  = cmd;
      b.dma  = dma;
      b.wbit = wbit;
      pending_beats.push_back(b);
      // zero-length writes are dropped by the block; leave them uncounted
      if (cmd == CMD_READ || dma != 16'h0000) counted_beats++;
   endfunction

   function logic [15:0] narrow_length();
      logic [15:0] len;
      do len = 16'($urandom_range(1, 16'hFFFF));
      while (len == sebp_pkg::WIDE_LEN_A || len == sebp_pkg::WIDE_LEN_B);
      return len;
   endfunction

   function logic [15:0] wide_length();
      return $urandom_range(0, 1) ? sebp_pkg::WIDE_LEN_A : sebp_pkg::WIDE_LEN_B;
   endfunction

   // length for the bit that brings the count to 'count'; a mixed header
   // strays to narrow lengths except at the bits that bring the count to 9 and 17
   function logic [15:0] header_length(logic wide, logic mixed, int count);
      if (!wide) return narrow_length();
      if (mixed && count != 9 && count != 17 && $urandom_range(0, 1)) return narrow_length();
      return wide_length();
   endfunction

   // a write bit, now and then preceded by a stray read or a zero-length write
   function void push_serial_bit(logic b, logic [15:0] dma);
      if ($urandom_range(0, 24) == 0) begin
         if ($urandom_range(0, 1)) push_beat(CMD_READ, 1'($urandom), 16'($urandom), 1'b0);
         else                      push_beat(CMD_WRITE, 1'($urandom), 16'h0000, 1'b0);
      end
      push_beat(CMD_WRITE, b, dma, 1'b0);
   endfunction

   // request bits, address and closing bit; the closing bit is the first
   // data bit of a write
   function void push_request(logic is_read, logic wide, logic mixed, logic [13:0] addr,
                              logic closing, logic hold);
      logic [16:0] hdr;
      int          n;
      n   = wide ? 17 : 9;
      hdr = wide ? {1'b1, is_read, addr, closing}
                 : {8'b0, 1'b1, is_read, addr[5:0], closing};
      push_beat(CMD_WRITE, hdr[n-1], header_length(wide, mixed, 1), hold);
      for (int c = 2; c <= n; c++) push_serial_bit(hdr[n-c], header_length(wide, mixed, c));
   endfunction

   function void write_transfer(logic wide, logic mixed, logic hold);
      logic [13:0] addr;
      logic [63:0] word;
      int          pick;
      addr = 14'($urandom);
      pick = $urandom_range(0, 9);
      word = (pick == 0) ? 64'h0 : (pick == 1) ? '1 : {$urandom, $urandom};
      push_request(1'b0, wide, mixed, addr, word[63], hold);
      for (int k = 62; k >= 0; k--) push_serial_bit(word[k], narrow_length());
      push_serial_bit(1'($urandom), narrow_length());   // stop bit
      written_words.push_back(wide ? addr[9:0] : {4'b0, addr[5:0]});
      if (written_words.size() > 8) void'(written_words.pop_front());
   endfunction

   // lead-in plus data reads; an abort cuts the read short with a write
   function void read_beats(bit abort);
      int n;
      n = abort ? $urandom_range(0, 67) : 68;
      for (int k = 0; k < n; k++) push_beat(CMD_READ, 1'($urandom), 16'($urandom), 1'b0);
      if (abort) push_beat(CMD_WRITE, 1'($urandom), narrow_length(), 1'b0);
   endfunction

   function void read_transfer(logic mixed, logic hold);
      logic [13:0] addr;
      logic [9:0]  word_sel;
      logic        wide;
      if (written_words.size() != 0 && $urandom_range(0, 9) < 7) begin
         // revisit a word that was written; bits above the store are masked
         word_sel = written_words[$urandom_range(0, written_words.size() - 1)];
         wide     = (word_sel >= 10'd64) || $urandom_range(0, 1);
         addr     = wide ? {4'($urandom), word_sel} : {8'($urandom), word_sel[5:0]};
      end else begin
         wide = $urandom_range(0, 1);
         addr = 14'($urandom);
      end
      wide = wide | mixed;
      push_request(1'b1, wide, mixed, addr, 1'($urandom), hold);
      read_beats($urandom_range(0, 6) == 0);
   endfunction

   // address phase that overruns: the count wraps through 127 and back to 9
   // under a narrow length; the last byte before the end is a read request
   function void runaway_transfer();
      logic [5:0] addr;
      logic [7:0] req;
      addr = 6'($urandom);
      req  = {2'b11, addr};
      push_beat(CMD_WRITE, 1'b1, narrow_length(), 1'b0);
      for (int i = 2; i <= 137; i++) begin
         if (i >= 129 && i <= 136)
            push_serial_bit(req[136 - i], narrow_length());
         else
            push_serial_bit(1'($urandom), (i <= 16) ? wide_length() : narrow_length());
      end
      read_beats(1'b0);
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: beats go out in bursts with random gaps; the model steps on each
   // accepted beat
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
         gap_left   = 0;
         burst_left = 0;
         clear_eeprom_state();
      end else begin
         if (req_tvalid && req_tready) predict_serial_access(on_bus);
         if (!req_tvalid || req_tready) begin
            if (burst_left == 0) begin
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               burst_left = $urandom_range(1, 40);
            end
            // hold a flagged beat back until every read bit is home
            if (gap_left != 0 || pending_beats.size() == 0 ||
                (pending_beats[0].hold && expected_read_bits.size() != 0)) begin
               if (gap_left != 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               on_bus = pending_beats.pop_front();
               burst_left--;
               req_tvalid <= 1'b1;
               req_tdata  <= {7'b0, on_bus.dma, on_bus.wbit};
               req_tuser  <= on_bus.cmd;
            end
         end
      end
   end

   // receiver: ready runs of random length broken by short stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_left = 0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (ready_left != 0) begin
         ready_left--;
         rsp_tready <= 1'b1;
      end else begin
         ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
         stall_left = $urandom_range(0, 5);
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: each accepted read bit against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_read_bits.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected read bit: expected none, actual %0b",
                     $time, rsp_tdata[0]);
         end else begin
            wanted_bit = expected_read_bits.pop_front();
            if (rsp_tdata[0] !== wanted_bit) begin
               mismatches++;
               $display("%0t: read_bit mismatch: expected %0b, actual %0b",
                        $time, wanted_bit, rsp_tdata[0]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: fill the beat queue, release reset, drain, report
   // ---------------------------------------------------------------------------
   initial begin
      int transfers;
      int runaways;
      int pick;
      transfers = 0;
      runaways  = 0;

      // idle reads answer 1; a zero-length write changes nothing
      push_beat(CMD_READ, 1'b0, 16'h0000, 1'b0);
      push_beat(CMD_READ, 1'b1, 16'hFFFF, 1'b0);
      push_beat(CMD_WRITE, 1'b1, 16'h0000, 1'b0);
      push_beat(CMD_READ, 1'b0, 16'h0000, 1'b0);
      // narrow read of word 0 at full length, a read in the middle of the
      // address answers 1
      push_beat(CMD_WRITE, 1'b1, 16'hFFFF, 1'b0);
      push_beat(CMD_WRITE, 1'b1, 16'hFFFF, 1'b0);
      push_beat(CMD_READ, 1'b1, 16'h0011, 1'b0);
      for (int i = 0; i < 7; i++) push_beat(CMD_WRITE, 1'b0, 16'hFFFF, 1'b0);
      // lead-in zeros, two data bits of an erased word, then a write aborts
      // once every read bit so far has come back
      for (int i = 0; i < 6; i++) push_beat(CMD_READ, 1'b0, 16'h0000, 1'b0);
      push_beat(CMD_WRITE, 1'b0, 16'h0001, 1'b1);
      push_beat(CMD_READ, 1'b1, 16'h0000, 1'b0);

      // random traffic, mostly well-formed transfers with random content
      while (counted_beats < BEAT_TARGET) begin
         pick = $urandom_range(0, 99);
         transfers++;
         if (pick < 40)
            write_transfer(1'($urandom), 1'b0, (transfers == 2) || ($urandom_range(0, 39) == 0));
         else if (pick < 78)
            read_transfer(1'b0, $urandom_range(0, 39) == 0);
         else if (pick < 86) begin
            if ($urandom_range(0, 1)) write_transfer(1'b1, 1'b1, 1'b0);
            else                      read_transfer(1'b1, 1'b0);
         end else if (pick < 88 && runaways < 2) begin
            runaways++;
            runaway_transfer();
         end else begin
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
               if ($urandom_range(0, 1)) push_beat(CMD_READ, 1'($urandom), 16'($urandom), 1'b0);
               else                      push_beat(CMD_WRITE, 1'($urandom), 16'h0000, 1'b0);
            end
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_tvalid || expected_read_bits.size() != 0)
         @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);

      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/sebp_pkg.sv
hdl/serial_eeprom_bit_protocol.sv
verif/serial_eeprom_bit_protocol_tb.sv
